/* hw/rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    localparam int FracBitsDefault = 8;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
        OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic [1:0]         status;
    } t_out_word;

    // simple-path result carried alongside the divider pipe
    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic               cmp;
        logic [1:0]         status;
        logic               a_neg;
        logic               q_neg;
        logic               div0;
    } t_side;
endpackage
`default_nettype wire

/* hw/rtl/fpa_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// One block of restoring-division steps on an unsigned numerator/divisor pair.
module fpa_div_stage #(
    parameter int NW    = 64,
    parameter int DW    = 33,
    parameter int STEPS = 8
) (
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [DW-1:0] i_den,
    output logic      [NW-1:0] o_num,
    output logic      [DW-1:0] o_rem
);
    always_comb begin
        logic [DW:0] t;
        o_num = i_num;
        o_rem = i_rem;
        for (int s = 0; s < STEPS; s++) begin
            t = {o_rem, o_num[NW-1]};
            o_num = {o_num[NW-2:0], 1'b0};
            if (t >= {1'b0, i_den}) begin
                t = t - {1'b0, i_den};
                o_num[0] = 1'b1;
            end
            o_rem = t[DW-1:0];
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/fixed_point_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits.
// Input channel i_in_* carries cmd and two raw operands; output channel
// o_out_* carries result_value, compare_true and status, one word per input.
// A word is taken when valid is high and stall is low.
// Every word passes through stage 0, NDS = ceil((33+FRAC_BITS)/8) divider
// stages and the output register, independent of opcode. Throughput is
// one word per cycle while the output is not stalled, set by the divider
// being cut into eight-step stages.
// Multiply uses a single 32x32 product stage; rounding and saturation follow.
// Reset clears all stage valid bits; no words are in flight afterwards.
// When the receiver stalls a valid output word, the whole pipe holds and
// o_in_stall rises in the same cycle, so nothing is lost or repeated.
// Overflow saturates with status 1; divide by zero saturates by sign of
// operand_a with status 2. Comparisons give result_value zero.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire fpa_pkg::t_in_word i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output fpa_pkg::t_out_word    o_out_data
);
    localparam int QB     = 33 + FRAC_BITS;        // quotient bits (2n+d)/(2d)
    localparam int DW     = 34;
    localparam int STEPS  = 8;
    localparam int NDS    = (QB + STEPS - 1) / STEPS;
    localparam int PAD    = NDS * STEPS;
    localparam int NS     = NDS + 1;               // stage regs after s0

    logic adv;
    assign adv = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // stage 0: decode, simple ops, product, division operands
    logic [NS:0]        r_v;
    fpa_pkg::t_side     r_side [NDS+1];
    logic signed [63:0] r_prod;
    logic [PAD-1:0]     r_num [NDS+1];
    logic [DW-1:0]      r_rem [NDS+1];
    logic [DW-1:0]      r_den [NDS+1];

    fpa_pkg::t_side     n_side;
    logic [PAD-1:0]     n_num;
    logic [DW-1:0]      n_den;

    always_comb begin
        logic signed [33:0] a, b, s;
        logic [32:0] ma, mb;
        logic signed [63:0] fi;
        a = 34'(i_in_data.operand_a);
        b = 34'(i_in_data.operand_b);
        ma = i_in_data.operand_a[31] ? 33'(-a) : 33'(a);
        mb = i_in_data.operand_b[31] ? 33'(-b) : 33'(b);
        n_side = '0;
        n_side.op = fpa_pkg::t_op'(i_in_data.cmd);
        n_side.a_neg = i_in_data.operand_a[31];
        n_side.q_neg = i_in_data.operand_a[31] ^ i_in_data.operand_b[31];
        n_side.div0 = (i_in_data.operand_b == 0);
        s = '0;
        case (n_side.op)
            fpa_pkg::OP_ADD: s = a + b;
            fpa_pkg::OP_SUB: s = a - b;
            fpa_pkg::OP_INC: s = a + 34'sd1;
            fpa_pkg::OP_DEC: s = a - 34'sd1;
            default:         s = '0;
        endcase
        if (s > 34'sh7FFFFFFF) begin
            n_side.value = 32'sh7FFFFFFF; n_side.status = fpa_pkg::ST_OVF;
        end else if (s < -34'sh80000000) begin
            n_side.value = -32'sh80000000; n_side.status = fpa_pkg::ST_OVF;
        end else begin
            n_side.value = s[31:0];
        end
        fi = 64'(i_in_data.operand_a) <<< FRAC_BITS;
        case (n_side.op)
            fpa_pkg::OP_GT: n_side.cmp = a > b;
            fpa_pkg::OP_LT: n_side.cmp = a < b;
            fpa_pkg::OP_GE: n_side.cmp = a >= b;
            fpa_pkg::OP_LE: n_side.cmp = a <= b;
            fpa_pkg::OP_EQ: n_side.cmp = a == b;
            fpa_pkg::OP_NE: n_side.cmp = a != b;
            default:        n_side.cmp = 1'b0;
        endcase
        case (n_side.op)
            fpa_pkg::OP_MIN: n_side.value = (a <= b) ? a[31:0] : b[31:0];
            fpa_pkg::OP_MAX: n_side.value = (a >= b) ? a[31:0] : b[31:0];
            fpa_pkg::OP_TO_INT: n_side.value = 32'(i_in_data.operand_a >>> FRAC_BITS);
            fpa_pkg::OP_FROM_INT: begin
                if (fi > 64'sh7FFFFFFF) begin
                    n_side.value = 32'sh7FFFFFFF; n_side.status = fpa_pkg::ST_OVF;
                end else if (fi < -64'sh80000000) begin
                    n_side.value = -32'sh80000000; n_side.status = fpa_pkg::ST_OVF;
                end else begin
                    n_side.value = fi[31:0];
                end
            end
            default: ;
        endcase
        // numerator 2*|a|<<F + |b|, divisor 2*|b|; leading zeros fill the pad
        n_num = PAD'(({31'd0, ma} << (FRAC_BITS + 1)) + {31'd0, mb});
        n_den = {mb, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            r_prod    <= 64'(i_in_data.operand_a) * 64'(i_in_data.operand_b);
            r_num[0]  <= n_num;
            r_rem[0]  <= '0;
            r_den[0]  <= n_den;
            for (int k = 1; k <= NDS; k++) r_side[k] <= r_side[k-1];
        end
    end

    // multiply rounding, one stage after product
    logic signed [31:0] r_mval;
    logic               r_movf;
    logic signed [31:0] r_mval_d [NDS-1];
    logic               r_movf_d [NDS-1];
    always_ff @(posedge i_clk) begin
        logic [63:0] mp, mr;
        if (adv) begin
            mp = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
            mr = (mp + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (!r_prod[63] && mr > 64'h7FFFFFFF) begin
                r_mval <= 32'sh7FFFFFFF; r_movf <= 1'b1;
            end else if (r_prod[63] && mr > 64'h80000000) begin
                r_mval <= -32'sh80000000; r_movf <= 1'b1;
            end else begin
                r_mval <= r_prod[63] ? 32'(-mr) : mr[31:0];
                r_movf <= 1'b0;
            end
            r_mval_d[0] <= r_mval;
            r_movf_d[0] <= r_movf;
            for (int k = 1; k < NDS - 1; k++) begin
                r_mval_d[k] <= r_mval_d[k-1];
                r_movf_d[k] <= r_movf_d[k-1];
            end
        end
    end

    for (genvar g = 0; g < NDS; g++) begin : g_div
        logic [PAD-1:0] w_num;
        logic [DW-1:0]  w_rem;
        fpa_div_stage #(.NW(PAD), .DW(DW), .STEPS(STEPS)) u_stage (
            .i_num(r_num[g]), .i_rem(r_rem[g]), .i_den(r_den[g]),
            .o_num(w_num), .o_rem(w_rem)
        );
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_num[g+1] <= w_num;
                r_rem[g+1] <= w_rem;
                r_den[g+1] <= r_den[g];
            end
        end
    end

    // final select; side info at index NDS aligns with divider output
    fpa_pkg::t_out_word r_out;
    always_ff @(posedge i_clk) begin
        fpa_pkg::t_side sd;
        logic [PAD-1:0] q;
        if (adv) begin
            sd = r_side[NDS];
            q  = r_num[NDS];
            r_out.result_value <= sd.value;
            r_out.compare_true <= sd.cmp;
            r_out.status       <= sd.status;
            if (sd.op == fpa_pkg::OP_MUL) begin
                r_out.result_value <= r_mval_d[NDS-2];
                r_out.status <= r_movf_d[NDS-2] ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end else if (sd.op == fpa_pkg::OP_DIV) begin
                if (sd.div0) begin
                    r_out.result_value <= sd.a_neg ? -32'sh80000000 : 32'sh7FFFFFFF;
                    r_out.status <= fpa_pkg::ST_DIV0;
                end else if (!sd.q_neg && q > PAD'(64'h7FFFFFFF)) begin
                    r_out.result_value <= 32'sh7FFFFFFF;
                    r_out.status <= fpa_pkg::ST_OVF;
                end else if (sd.q_neg && q > PAD'(64'h80000000)) begin
                    r_out.result_value <= -32'sh80000000;
                    r_out.status <= fpa_pkg::ST_OVF;
                end else begin
                    r_out.result_value <= sd.q_neg ? 32'(-q) : q[31:0];
                    r_out.status <= fpa_pkg::ST_OK;
                end
            end
        end
    end

    assign o_out_valid = r_v[NDS+1];
    assign o_out_data  = r_out;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output word changed under stall");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.compare_true) |->
        (o_out_data.result_value == 0 && o_out_data.status == fpa_pkg::ST_OK))
        else $error("comparison with nonzero value");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("bad status code");
    a_side_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NDS-1] && adv) |=> (r_side[NDS] == $past(r_side[NDS-1])))
        else $error("side pipe misaligned");
endmodule
`default_nettype wire
